// ===== rtl/core/ghp_pkg.sv =====
// Types and constants for the gzip header parser.
// No dependencies; imported by the parser and its checker.
`default_nettype none

package ghp_pkg;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLO     = 4'd1,
    PH_XHI     = 4'd2,
    PH_EXTRA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HLO     = 4'd6,
    PH_HHI     = 4'd7,
    PH_END     = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ST_PARSING  = 3'd0,
    ST_DONE     = 3'd1,
    ST_SMALL    = 3'd2,
    ST_MAGIC    = 3'd3,
    ST_METHOD   = 3'd4,
    ST_RESERVED = 3'd5,
    ST_OVERRUN  = 3'd6
  } status_e;

  // optional-field stage to resume from
  typedef enum logic [2:0] {
    SG_EXTRA   = 3'd0,
    SG_NAME    = 3'd1,
    SG_COMMENT = 3'd2,
    SG_HCRC    = 3'd3,
    SG_END     = 3'd4
  } stage_e;

  typedef struct packed {
    phase_e  phase;
    status_e status;
  } enter_t;

  localparam logic [7:0]  MAGIC0       = 8'h1f;
  localparam logic [7:0]  MAGIC1       = 8'h8b;
  localparam logic [7:0]  METHOD_DEFL  = 8'd8;
  localparam logic [7:0]  FLG_RESERVED = 8'he0;
  localparam logic [31:0] MIN_SIZE     = 32'd18;
  localparam logic [31:0] TRAILER_LEN  = 32'd8;
  localparam int          FIXED_LEN    = 10;

  localparam int FLG_FHCRC    = 1;
  localparam int FLG_FEXTRA   = 2;
  localparam int FLG_FNAME    = 3;
  localparam int FLG_FCOMMENT = 4;

endpackage

`default_nettype wire

// ===== rtl/core/gzip_header_parser.sv =====
// gzip (RFC 1952) header parser: one byte in, one sticky status out.
// Depends on ghp_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, data_byte_i, first_byte_i | request in
//   out     | out_valid_o/out_ready_i, status_o, payload_offset_o,
//           | header_flags_o                            | request out
//   cfg     | cfg_we_i, cfg_wdata_i (file size)         | write only
//
// One byte per cycle while the output is not stalled: the parse state and the
// result register update at the edge that accepts the byte, so the result shows in the next cycle.
// in_ready_o is high whenever the result register is empty or being drained.
// Reset (rst_ni low, async) restarts parsing and clears file size to zero.
// A stall on the output holds the result and blocks further input.
`default_nettype none

module gzip_header_parser
  import ghp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [31:0]      payload_offset_o,
  output logic [4:0]       header_flags_o
);

  localparam int CW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  logic [31:0]            fsize_q;
  logic [OFFSET_BITS-1:0] off_q, off_d, cur_off, nxt_off;
  phase_e                 phase_q, phase_d, cur_phase;
  logic [4:0]             flags_q, flags_d, cur_flags;
  logic [15:0]            xrem_q, xrem_d, cur_xrem, xlen;
  status_e                st_q, st_d, cur_st;
  logic                   in_acc;
  logic [CW-1:0]          o_ext, lim_ext;
  enter_t                 ent;

  logic                   out_valid_q;
  logic [2:0]             status_q;
  logic [31:0]            poff_q;
  logic [4:0]             hflags_q;

  function automatic enter_t enter_stage(stage_e s, logic [4:0] flg,
                                         logic [CW-1:0] o, logic [CW-1:0] lim);
    enter_t r;
    r.phase  = PH_END;
    r.status = ST_PARSING;
    if (s <= SG_EXTRA && flg[FLG_FEXTRA]) begin
      if (o + CW'(2) > lim) r.status = ST_OVERRUN;
      else r.phase = PH_XLO;
    end else if (s <= SG_NAME && flg[FLG_FNAME]) begin
      if (o >= lim) r.status = ST_OVERRUN;
      else r.phase = PH_NAME;
    end else if (s <= SG_COMMENT && flg[FLG_FCOMMENT]) begin
      if (o >= lim) r.status = ST_OVERRUN;
      else r.phase = PH_COMMENT;
    end else if (s <= SG_HCRC && flg[FLG_FHCRC]) begin
      if (o + CW'(2) > lim) r.status = ST_OVERRUN;
      else r.phase = PH_HLO;
    end else begin
      r.status = (o > lim) ? ST_OVERRUN : ST_DONE;
    end
    return r;
  endfunction

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    if (first_byte_i) begin
      cur_off   = '0;
      cur_phase = PH_FIXED;
      cur_flags = '0;
      cur_xrem  = '0;
      cur_st    = ST_PARSING;
    end else begin
      cur_off   = off_q;
      cur_phase = phase_q;
      cur_flags = flags_q;
      cur_xrem  = xrem_q;
      cur_st    = st_q;
    end
  end

  assign nxt_off = cur_off + OFFSET_BITS'(1);
  assign o_ext   = CW'(nxt_off);
  assign lim_ext = CW'(fsize_q - TRAILER_LEN);

  always_comb begin
    off_d   = cur_off;
    phase_d = cur_phase;
    flags_d = cur_flags;
    xrem_d  = cur_xrem;
    st_d    = cur_st;
    xlen    = {data_byte_i, cur_xrem[7:0]};
    ent     = enter_stage(SG_END, cur_flags, o_ext, lim_ext);
    if (cur_st == ST_PARSING) begin
      if (fsize_q < MIN_SIZE) begin
        st_d    = ST_SMALL;
        phase_d = PH_END;
      end else if (cur_off == '1) begin
        st_d    = ST_OVERRUN;
        phase_d = PH_END;
      end else begin
        off_d = nxt_off;
        case (cur_phase)
          PH_FIXED: begin
            if (cur_off == OFFSET_BITS'(0) && data_byte_i != MAGIC0) begin
              st_d = ST_MAGIC; phase_d = PH_END;
            end else if (cur_off == OFFSET_BITS'(1) && data_byte_i != MAGIC1) begin
              st_d = ST_MAGIC; phase_d = PH_END;
            end else if (cur_off == OFFSET_BITS'(2) && data_byte_i != METHOD_DEFL) begin
              st_d = ST_METHOD; phase_d = PH_END;
            end else if (cur_off == OFFSET_BITS'(3)
                         && (data_byte_i & FLG_RESERVED) != 8'd0) begin
              st_d = ST_RESERVED; phase_d = PH_END;
            end else begin
              if (cur_off == OFFSET_BITS'(3)) flags_d = data_byte_i[4:0];
              if (nxt_off >= OFFSET_BITS'(FIXED_LEN)) begin
                ent     = enter_stage(SG_EXTRA, flags_d, o_ext, lim_ext);
                phase_d = ent.phase;
                st_d    = ent.status;
              end
            end
          end
          PH_XLO: begin
            xrem_d  = {8'd0, data_byte_i};
            phase_d = PH_XHI;
          end
          PH_XHI: begin
            xrem_d = xlen;
            if (o_ext > lim_ext || CW'(xlen) > lim_ext - o_ext) begin
              st_d = ST_OVERRUN; phase_d = PH_END;
            end else if (xlen == 16'd0) begin
              ent     = enter_stage(SG_NAME, cur_flags, o_ext, lim_ext);
              phase_d = ent.phase;
              st_d    = ent.status;
            end else begin
              phase_d = PH_EXTRA;
            end
          end
          PH_EXTRA: begin
            xrem_d = cur_xrem - 16'd1;
            if (xrem_d == 16'd0) begin
              ent     = enter_stage(SG_NAME, cur_flags, o_ext, lim_ext);
              phase_d = ent.phase;
              st_d    = ent.status;
            end
          end
          PH_NAME, PH_COMMENT: begin
            if (data_byte_i == 8'd0) begin
              ent = enter_stage((cur_phase == PH_NAME) ? SG_COMMENT : SG_HCRC,
                                cur_flags, o_ext, lim_ext);
              phase_d = ent.phase;
              st_d    = ent.status;
            end else if (o_ext >= lim_ext) begin
              st_d = ST_OVERRUN; phase_d = PH_END;
            end
          end
          PH_HLO: phase_d = PH_HHI;
          PH_HHI: begin
            phase_d = ent.phase;
            st_d    = ent.status;
          end
          default: begin
            st_d = ST_OVERRUN; phase_d = PH_END;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsize_q <= '0;
      off_q   <= '0;
      phase_q <= PH_FIXED;
      flags_q <= '0;
      xrem_q  <= '0;
      st_q    <= ST_PARSING;
    end else begin
      if (cfg_we_i) fsize_q <= cfg_wdata_i;
      if (in_acc) begin
        off_q   <= off_d;
        phase_q <= phase_d;
        flags_q <= flags_d;
        xrem_q  <= xrem_d;
        st_q    <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= st_d;
      poff_q   <= (st_d == ST_DONE) ? 32'(off_d) : 32'd0;
      hflags_q <= flags_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign payload_offset_o = poff_q;
  assign header_flags_o   = hflags_q;

endmodule

`default_nettype wire

// ===== rtl/core/ghp_checker.sv =====
// Port-level checker for gzip_header_parser, bound into every parser instance.
// Depends on ghp_pkg.
`default_nettype none

module ghp_checker
  import ghp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] payload_offset_o,
  input wire logic [4:0]  header_flags_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(payload_offset_o) && $stable(header_flags_o))
    else $error("result changed while stalled");

  a_offset_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> payload_offset_o == 32'd0)
    else $error("payload offset without done status");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

endmodule

bind gzip_header_parser ghp_checker u_ghp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .payload_offset_o (payload_offset_o),
  .header_flags_o   (header_flags_o)
);

`default_nettype wire
